@@ sv/alfid_pkg.sv @@
// Package with the shared types, codes and sizes of the array list block.
package alfid_pkg;

    // List capacity and the widths that follow from it.
    localparam int DEPTH  = 512;
    localparam int IDX_W  = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int POS_W  = 9;
    localparam int FIDX_W = 9;
    localparam int CNTO_W = 10;
    localparam int DATA_W = 32;
    localparam int WIDE_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    // Match bits are scanned this many at a time.
    localparam int GRP        = 8;
    localparam int NUM_GROUPS = (DEPTH + GRP - 1) / GRP;
    localparam int GIDX_W     = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;

    // Operation codes carried by an input item.
    typedef enum logic [1:0] {
        OP_FIND   = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2,
        OP_NOP    = 2'd3
    } opcode_t;

    // Status codes carried by a result item.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_BADPOS   = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    // Command broadcast to every cell.
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_DELETE = 2'd2,
        CELL_MATCH  = 2'd3
    } cell_op_t;

    // Control states of the top level.
    typedef enum logic {
        S_IDLE = 1'b0,
        S_SCAN = 1'b1
    } state_t;

    typedef struct packed {
        logic [1:0]               opcode;
        logic signed [DATA_W-1:0] value;
        logic [POS_W-1:0]         position;
    } in_item_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [FIDX_W-1:0] found_index;
        logic [CNTO_W-1:0] element_count;
    } out_item_t;

    typedef struct packed {
        cell_op_t                 op;
        logic [WIDE_W-1:0]        pos;
        logic [WIDE_W-1:0]        cnt;
        logic signed [DATA_W-1:0] value;
    } cell_cmd_t;

    typedef struct packed {
        logic start;
        logic take;
    } scan_ctl_t;

    typedef struct packed {
        logic             done;
        logic             hit;
        logic [IDX_W-1:0] index;
    } scan_res_t;

endpackage

@@ sv/array_list_find_insert_delete.sv @@
// Top level of the array list: control, element count, cell chain and scan.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+---------------------------------------
//  in       | in_valid / in_ready   | in_data  (opcode, value, position)
//  out      | out_valid / out_ready | out_data (status, found_index, count)
//
// Insert and delete shift the cell chain from the given position upward as the
// item is taken; the unused opcode only reports. Find compares in all cells into
// registered match bits, which the scan unit then walks eight match bits per cycle.
// Reset empties the list at once; no clearing pass is needed.
// A result waiting in the output register holds off the next item until it
// is taken, and no item is taken while a find is scanning.
module array_list_find_insert_delete (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  alfid_pkg::in_item_t  in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output alfid_pkg::out_item_t out_data
);
    import alfid_pkg::*;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_reg, out_next;
    logic              accept;
    logic              out_free;
    cell_cmd_t         cmd;
    scan_ctl_t         sctl;
    scan_res_t         sres;
    logic [WIDE_W-1:0] pos_w;
    logic [WIDE_W-1:0] cnt_w;

    logic signed [DATA_W-1:0] elems [DEPTH];
    logic [DEPTH-1:0]         match_bits;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE) && out_free;
    assign accept   = in_valid && in_ready;
    assign pos_w    = WIDE_W'(in_data.position);
    assign cnt_w    = WIDE_W'(count_reg);

    // Chain of cells, one per list entry.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [DATA_W-1:0] left_elem;
        logic signed [DATA_W-1:0] right_elem;

        if (i == 0)
        begin : g_first
            assign left_elem = in_data.value;
        end
        else
        begin : g_mid_l
            assign left_elem = elems[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_elem = elems[i];
        end
        else
        begin : g_mid_r
            assign right_elem = elems[i+1];
        end

        alfid_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .idx        (IDX_W'(i)),
            .cmd        (cmd),
            .left_elem  (left_elem),
            .right_elem (right_elem),
            .elem       (elems[i]),
            .match      (match_bits[i])
        );
    end

    alfid_scan u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (sctl),
        .match (match_bits),
        .count (count_reg),
        .res   (sres)
    );

    // Decode the accepted item, drive the cells and build the result.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        cmd.op         = CELL_HOLD;
        cmd.pos        = pos_w;
        cmd.cnt        = cnt_w;
        cmd.value      = in_data.value;
        sctl.start     = 1'b0;
        sctl.take      = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    out_next.status      = ST_OK;
                    out_next.found_index = '0;
                    unique case (opcode_t'(in_data.opcode))
                        OP_FIND:
                        begin
                            cmd.op     = CELL_MATCH;
                            sctl.start = 1'b1;
                            state_next = S_SCAN;
                        end
                        OP_INSERT:
                        begin
                            if (count_reg == CNT_W'(DEPTH))
                            begin
                                out_next.status = ST_FULL;
                            end
                            else if (pos_w > cnt_w)
                            begin
                                out_next.status = ST_BADPOS;
                            end
                            else
                            begin
                                cmd.op     = CELL_INSERT;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_DELETE:
                        begin
                            if (pos_w >= cnt_w)
                            begin
                                out_next.status = ST_BADPOS;
                            end
                            else
                            begin
                                cmd.op     = CELL_DELETE;
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        default:
                        begin
                            out_next.status = ST_OK;
                        end
                    endcase
                    out_next.element_count = CNTO_W'(count_next);
                    if (opcode_t'(in_data.opcode) != OP_FIND)
                    begin
                        out_valid_next = 1'b1;
                    end
                end
            end
            S_SCAN:
            begin
                if (sres.done && out_free)
                begin
                    sctl.take              = 1'b1;
                    out_valid_next         = 1'b1;
                    out_next.element_count = CNTO_W'(count_reg);
                    if (sres.hit)
                    begin
                        out_next.status      = ST_OK;
                        out_next.found_index = FIDX_W'(sres.index);
                    end
                    else
                    begin
                        out_next.status      = ST_NOTFOUND;
                        out_next.found_index = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

@@ sv/alfid_cell.sv @@
// One list entry: holds an element, shifts with its neighbors and compares.
module alfid_cell (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [alfid_pkg::IDX_W-1:0]       idx,
    input  alfid_pkg::cell_cmd_t              cmd,
    input  logic signed [alfid_pkg::DATA_W-1:0] left_elem,
    input  logic signed [alfid_pkg::DATA_W-1:0] right_elem,
    output logic signed [alfid_pkg::DATA_W-1:0] elem,
    output logic                              match
);
    import alfid_pkg::*;

    logic signed [DATA_W-1:0] elem_reg, elem_next;
    logic                     match_reg, match_next;
    logic [WIDE_W-1:0]        idx_w;

    assign idx_w = WIDE_W'(idx);

    // Element update: take the left neighbor above the insert point, the new
    // value at it, and the right neighbor from the delete point upward.
    always_comb
    begin
        elem_next  = elem_reg;
        match_next = match_reg;
        unique case (cmd.op)
            CELL_INSERT:
            begin
                if (idx_w > cmd.pos)
                begin
                    elem_next = left_elem;
                end
                else if (idx_w == cmd.pos)
                begin
                    elem_next = cmd.value;
                end
            end
            CELL_DELETE:
            begin
                if (idx_w >= cmd.pos)
                begin
                    elem_next = right_elem;
                end
            end
            CELL_MATCH:
            begin
                match_next = (elem_reg == cmd.value) && (idx_w < cmd.cnt);
            end
            default:
            begin
                elem_next = elem_reg;
            end
        endcase
    end

    // Element storage needs no reset; the match flag does.
    always_ff @(posedge clk)
    begin
        elem_reg <= elem_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
        end
    end

    assign elem  = elem_reg;
    assign match = match_reg;

endmodule

@@ sv/alfid_scan.sv @@
// Walks the registered match bits one group per cycle to find the first hit.
module alfid_scan (
    input  logic                               clk,
    input  logic                               rst_n,
    input  alfid_pkg::scan_ctl_t               ctl,
    input  logic [alfid_pkg::DEPTH-1:0]        match,
    input  logic [alfid_pkg::CNT_W-1:0]        count,
    output alfid_pkg::scan_res_t               res
);
    import alfid_pkg::*;

    localparam int PAD_W  = NUM_GROUPS * GRP;
    localparam int GSEL_W = $clog2(GRP);
    localparam int CMP_W  = ((GIDX_W + GSEL_W + 1 > CNT_W) ? GIDX_W + GSEL_W + 1 : CNT_W);

    logic                  active_reg, active_next;
    logic [GIDX_W-1:0]     grp_reg, grp_next;
    logic [PAD_W-1:0]      match_pad;
    logic [GRP-1:0]        slice;
    logic [GSEL_W-1:0]     enc;
    logic                  any_hit;
    logic                  last_grp;
    logic [CMP_W-1:0]      next_base;

    assign match_pad = PAD_W'(match);
    assign slice     = match_pad[grp_reg*GRP +: GRP];

    // Lowest set bit of the current group.
    always_comb
    begin
        enc     = '0;
        any_hit = 1'b0;
        for (int k = GRP - 1; k >= 0; k--)
        begin
            if (slice[k])
            begin
                enc     = GSEL_W'(k);
                any_hit = 1'b1;
            end
        end
    end

    // The scan ends at the last group or once the next group lies past the count.
    assign next_base = {CMP_W'(grp_reg) + CMP_W'(1)} << GSEL_W;
    assign last_grp  = (grp_reg == GIDX_W'(NUM_GROUPS - 1)) ||
                       (next_base >= CMP_W'(count));

    assign res.done  = active_reg && (any_hit || last_grp);
    assign res.hit   = any_hit;
    assign res.index = IDX_W'({grp_reg, enc});

    // Group counter: restart on a new find, advance until done.
    always_comb
    begin
        active_next = active_reg;
        grp_next    = grp_reg;
        priority if (ctl.start)
        begin
            active_next = 1'b1;
            grp_next    = '0;
        end
        else if (ctl.take)
        begin
            active_next = 1'b0;
        end
        else if (active_reg && !res.done)
        begin
            grp_next = grp_reg + GIDX_W'(1);
        end
        else
        begin
            grp_next = grp_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            grp_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            grp_reg    <= grp_next;
        end
    end

endmodule

@@ sv/alfid_check.sv @@
// Port checker for the array list, bound to the top level.
module alfid_check (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input alfid_pkg::out_item_t out_data
);
    import alfid_pkg::*;

    // A result that is not taken stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // No item is taken while a result waits to be taken.
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input ready while a result is stalled");

    // The count never exceeds the capacity.
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.element_count <= CNTO_W'(DEPTH))
        else $error("element count above capacity");

    // A full report comes only from a full list.
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == ST_FULL |->
            out_data.element_count == CNTO_W'(DEPTH))
        else $error("full status with room left");

    // A found index lies inside the list and is zero on any failure.
    a_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.status == ST_OK &&
            CNTO_W'(out_data.found_index) < out_data.element_count) ||
            out_data.found_index == '0)
        else $error("found index outside the list");

endmodule

bind array_list_find_insert_delete alfid_check u_alfid_check (.*);

@@ tb/tb_array_list_find_insert_delete.sv @@
// Self-checking testbench for the array list block: directed table, then phased random traffic.
`timescale 1ns / 100ps

module tb_array_list_find_insert_delete;
    import alfid_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 5;
    localparam int RANDOM_ITEMS = 1630;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int TAIL_CYCLES  = 2 * (DEPTH / GRP) + 20;
    localparam int HOLD_AT      = 400;
    localparam int LONG_HOLD    = 600;
    localparam int FULL_ITEMS   = 20;
    localparam int MAX_REPORTS  = 10;

    // One row of the directed table; exp is used only when typed is set.
    typedef struct {
        in_item_t  item;
        bit        typed;
        out_item_t exp;
    } dir_row_t;

    // Random traffic walks the list up to full, back down to empty, then mixes.
    typedef enum {
        PH_FILL,
        PH_DRAIN,
        PH_MIX
    } stim_phase_t;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;

    // Shadow copy of the list, kept in step with every accepted item.
    logic signed [DATA_W-1:0] list_mem [DEPTH];
    int                       list_len;

    out_item_t   result_q [$];
    dir_row_t    dir_rows [$];
    int          mismatch_count;
    int          cycle_count;
    stim_phase_t phase;
    int          full_items_seen;

    array_list_find_insert_delete dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // Free-running clock.
    initial clk = 1'b0;
    always #(CLK_HALF) clk = ~clk;

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_array_list_find_insert_delete failed");
            $finish;
        end
    end

    // Apply one operation to the shadow list and return the result it gives.
    function automatic out_item_t apply_list_op(input in_item_t item);
        out_item_t res;
        int        i;
        res.status      = ST_OK;
        res.found_index = '0;
        case (opcode_t'(item.opcode))
            OP_FIND:
            begin
                res.status = ST_NOTFOUND;
                for (i = 0; i < list_len; i++)
                begin
                    if (list_mem[i] == item.value)
                    begin
                        res.status      = ST_OK;
                        res.found_index = FIDX_W'(i);
                        break;
                    end
                end
            end
            OP_INSERT:
            begin
                if (list_len >= DEPTH)
                    res.status = ST_FULL;
                else if (int'(item.position) > list_len)
                    res.status = ST_BADPOS;
                else
                begin
                    for (i = list_len; i > int'(item.position); i--)
                        list_mem[i] = list_mem[i - 1];
                    list_mem[item.position] = item.value;
                    list_len++;
                end
            end
            OP_DELETE:
            begin
                if (int'(item.position) >= list_len)
                    res.status = ST_BADPOS;
                else
                begin
                    for (i = int'(item.position) + 1; i < list_len; i++)
                        list_mem[i - 1] = list_mem[i];
                    list_len--;
                end
            end
            default:
            begin
            end
        endcase
        res.element_count = CNTO_W'(list_len);
        return res;
    endfunction

    function automatic dir_row_t mk_row(input opcode_t op, input logic signed [DATA_W-1:0] val,
                                        input int pos, input bit typed, input status_t st,
                                        input int cnt);
        dir_row_t row;
        row.item.opcode            = op;
        row.item.value             = val;
        row.item.position          = POS_W'(pos);
        row.typed                  = typed;
        row.exp.status             = st;
        row.exp.found_index        = '0;
        row.exp.element_count      = CNTO_W'(cnt);
        return row;
    endfunction

    // Values lean on a small pool so that finds hit and duplicates occur.
    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1:
            begin
                case ($urandom_range(0, 3))
                    0: return 32'sh7FFF_FFFF;
                    1: return 32'sh8000_0000;
                    2: return 32'sd0;
                    default: return -32'sd1;
                endcase
            end
            default: return 32'($urandom_range(0, 15)) - 32'sd8;
        endcase
    endfunction

    // Build the next random item from the current phase and shadow list.
    function automatic in_item_t next_random_item();
        in_item_t item;
        int       roll;
        int       ins_cut;
        int       find_cut;
        int       del_cut;
        int       top_pos;

        if (phase == PH_FILL && list_len == DEPTH)
        begin
            full_items_seen++;
            if (full_items_seen >= FULL_ITEMS)
                phase = PH_DRAIN;
        end
        else if (phase == PH_DRAIN && list_len == 0)
            phase = PH_MIX;

        case (phase)
            PH_FILL:  begin ins_cut = 80; find_cut = 90; del_cut = 95; end
            PH_DRAIN: begin ins_cut = 5;  find_cut = 15; del_cut = 95; end
            default:  begin ins_cut = 35; find_cut = 60; del_cut = 90; end
        endcase

        roll          = $urandom_range(0, 99);
        item.value    = pick_value();
        item.position = POS_W'($urandom);
        top_pos       = (list_len > DEPTH - 1) ? DEPTH - 1 : list_len;

        if (roll < ins_cut)
        begin
            item.opcode   = OP_INSERT;
            item.position = POS_W'($urandom_range(0, top_pos));
        end
        else if (roll < find_cut)
        begin
            item.opcode = OP_FIND;
            if (list_len > 0 && $urandom_range(0, 9) < 7)
                item.value = list_mem[$urandom_range(0, list_len - 1)];
        end
        else if (roll < del_cut)
        begin
            item.opcode = OP_DELETE;
            item.value  = $urandom;
            if (list_len > 0)
                item.position = POS_W'($urandom_range(0, list_len - 1));
        end
        else
        begin
            // Noise: any opcode, any value, any position.
            item.opcode = 2'($urandom_range(0, 3));
            item.value  = $urandom;
        end
        return item;
    endfunction

    // Offer one item from a falling edge and return at the falling edge after it is taken.
    task automatic offer_item(input in_item_t item, input int gap, input bit typed,
                              input out_item_t typed_exp);
        out_item_t pred;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do
            @(posedge clk);
        while (!in_ready);
        pred = apply_list_op(item);
        result_q.push_back(typed ? typed_exp : pred);
        @(negedge clk);
    endtask

    task automatic flag_mismatch(input string what, input longint exp, input longint got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch in %s: expected %0d, got %0d", what, exp, got);
    endtask

    // Compare every result item with the oldest expectation.
    always @(posedge clk)
    begin
        out_item_t exp;
        if (rst_n && out_valid && out_ready)
        begin
            if (result_q.size() == 0)
                flag_mismatch("unexpected result, element_count", -1, out_data.element_count);
            else
            begin
                exp = result_q.pop_front();
                if (out_data.status !== exp.status)
                    flag_mismatch("status", exp.status, out_data.status);
                if (out_data.found_index !== exp.found_index)
                    flag_mismatch("found_index", exp.found_index, out_data.found_index);
                if (out_data.element_count !== exp.element_count)
                    flag_mismatch("element_count", exp.element_count, out_data.element_count);
            end
        end
    end

    // Result side: random stalls, bursts without stalls, and one long hold-off.
    initial
    begin : result_side
        int  hold;
        int  taken;
        bit  rx_burst;
        taken     = 0;
        rx_burst  = 1'b0;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (taken % 64 == 0)
                rx_burst = ($urandom_range(0, 3) == 0);
            if (taken == HOLD_AT)
                hold = LONG_HOLD;
            else
                hold = rx_burst ? 0 : $urandom_range(0, 9);
            if (hold > 0)
            begin
                out_ready <= 1'b0;
                repeat (hold) @(negedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            taken++;
            @(negedge clk);
        end
    end

    // Input side: reset, directed table, phased random items, then drain.
    initial
    begin : input_side
        in_item_t  item;
        out_item_t no_exp;
        int        gap;
        int        n;
        bit        tx_burst;

        rst_n           = 1'b0;
        in_valid        = 1'b0;
        in_data         = '0;
        list_len        = 0;
        mismatch_count  = 0;
        cycle_count     = 0;
        phase           = PH_FILL;
        full_items_seen = 0;
        tx_burst        = 1'b0;
        no_exp          = '0;

        // Directed table: empty list, extremes, error codes, duplicates, no-op.
        dir_rows.push_back(mk_row(OP_FIND,   32'sd0,           0,   1, ST_NOTFOUND, 0));
        dir_rows.push_back(mk_row(OP_DELETE, 32'sd0,           0,   1, ST_BADPOS,   0));
        dir_rows.push_back(mk_row(OP_INSERT, 32'sd5,           1,   1, ST_BADPOS,   0));
        dir_rows.push_back(mk_row(OP_INSERT, 32'sh7FFF_FFFF,   0,   1, ST_OK,       1));
        dir_rows.push_back(mk_row(OP_INSERT, 32'sh8000_0000,   1,   1, ST_OK,       2));
        dir_rows.push_back(mk_row(OP_INSERT, 32'sd0,           0,   1, ST_OK,       3));
        dir_rows.push_back(mk_row(OP_INSERT, -32'sd1,          2,   1, ST_OK,       4));
        dir_rows.push_back(mk_row(OP_FIND,   32'sh8000_0000,   0,   0, ST_OK,       0));
        dir_rows.push_back(mk_row(OP_FIND,   32'sh7FFF_FFFF,   511, 0, ST_OK,       0));
        dir_rows.push_back(mk_row(OP_FIND,   -32'sd1,          0,   0, ST_OK,       0));
        dir_rows.push_back(mk_row(OP_FIND,   32'sd12345,       0,   1, ST_NOTFOUND, 4));
        dir_rows.push_back(mk_row(OP_INSERT, 32'sd7,           511, 1, ST_BADPOS,   4));
        dir_rows.push_back(mk_row(OP_NOP,    -32'sd1,          511, 1, ST_OK,       4));
        dir_rows.push_back(mk_row(OP_INSERT, -32'sd1,          0,   0, ST_OK,       0));
        dir_rows.push_back(mk_row(OP_FIND,   -32'sd1,          0,   0, ST_OK,       0));
        dir_rows.push_back(mk_row(OP_DELETE, 32'sd0,           511, 1, ST_BADPOS,   5));
        dir_rows.push_back(mk_row(OP_DELETE, 32'sd0,           5,   1, ST_BADPOS,   5));
        dir_rows.push_back(mk_row(OP_DELETE, -32'sd1,          4,   0, ST_OK,       0));
        dir_rows.push_back(mk_row(OP_DELETE, 32'sd0,           0,   0, ST_OK,       0));
        dir_rows.push_back(mk_row(OP_FIND,   32'sh7FFF_FFFF,   0,   0, ST_OK,       0));
        dir_rows.push_back(mk_row(OP_NOP,    32'sd0,           0,   1, ST_OK,       3));
        dir_rows.push_back(mk_row(OP_INSERT, 32'sh5555_5555,   3,   0, ST_OK,       0));
        dir_rows.push_back(mk_row(OP_INSERT, 32'shAAAA_AAAA,   1,   0, ST_OK,       0));

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
            offer_item(dir_rows[i].item, $urandom_range(0, 9), dir_rows[i].typed,
                       dir_rows[i].exp);

        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 50 == 0)
                tx_burst = ($urandom_range(0, 3) == 0);
            gap  = tx_burst ? 0 : $urandom_range(0, 9);
            item = next_random_item();
            offer_item(item, gap, 1'b0, no_exp);
        end
        in_valid <= 1'b0;

        // Let every result come back, then watch for strays.
        wait (result_q.size() == 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_array_list_find_insert_delete passed");
        else
            $display("tb_array_list_find_insert_delete failed");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/alfid_pkg.sv
sv/alfid_cell.sv
sv/alfid_scan.sv
sv/array_list_find_insert_delete.sv
sv/alfid_check.sv
tb/tb_array_list_find_insert_delete.sv
